// ===== hw/rtl/ntfh_pkg.sv =====
// Package with types, constants and helpers for the normalized text hash core.
`timescale 1ns / 1ps
package ntfh_pkg;
  localparam int HOLD_DEPTH_DEF = 64;
  localparam int NEWLINE_COUNT_BITS_DEF = 16;
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam logic [3:0] KEY_LEN = 4'd7;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_EQ = 8'h3d;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_value;
    logic        body_empty;
    logic        hold_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_LEAD, PH_KEY, PH_TAIL, PH_KEEP, PH_DROP
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BYTE, ST_KDEBT, ST_KRD, ST_KEM, ST_KCUR,
    ST_ESET, ST_EDEBT, ST_ERD, ST_EEM, ST_END, ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic classify;
    logic debt_step;
    logic emit_held;
    logic emit_cur;
    logic end_start;
    logic end_done;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_lf;
    logic is_last;
    logic emit;
    logic flush_more;
    logic debt_more;
  } sts_t;

  function automatic logic [7:0] key_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = 8'h66;
      4'd1: c = 8'h72;
      4'd2: c = 8'h61;
      4'd3: c = 8'h74;
      4'd4: c = 8'h69;
      4'd5: c = 8'h6e;
      4'd6: c = 8'h67;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  // The FNV prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction
endpackage

// ===== hw/rtl/ntfh_ctrl.sv =====
// Controller state machine that sequences byte handling, flushes and line ends.
`timescale 1ns / 1ps
module ntfh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           out_full,
  input  ntfh_pkg::sts_t sts,
  output ntfh_pkg::cmd_t cmd
);
  import ntfh_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_BYTE;
      end
      ST_BYTE: begin
        if (sts.is_lf) state_next = ST_ESET;
        else if (sts.emit) state_next = ST_KDEBT;
        else if (sts.is_last) state_next = ST_ESET;
        else state_next = ST_IDLE;
      end
      ST_KDEBT: begin
        if (!sts.debt_more) state_next = ST_KRD;
      end
      ST_KRD: state_next = sts.flush_more ? ST_KEM : ST_KCUR;
      ST_KEM: state_next = ST_KRD;
      ST_KCUR: state_next = sts.is_last ? ST_ESET : ST_IDLE;
      ST_ESET: state_next = ST_EDEBT;
      ST_EDEBT: begin
        if (!(sts.flush_more && sts.debt_more)) state_next = ST_ERD;
      end
      ST_ERD: state_next = sts.flush_more ? ST_EEM : ST_END;
      ST_EEM: state_next = ST_ERD;
      ST_END: begin
        if (sts.is_last) state_next = sts.is_lf ? ST_ESET : ST_OUT;
        else state_next = ST_IDLE;
      end
      ST_OUT: begin
        if (!out_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      ST_BYTE: cmd.classify = 1'b1;
      ST_KDEBT: cmd.debt_step = 1'b1;
      ST_KEM: cmd.emit_held = 1'b1;
      ST_KCUR: cmd.emit_cur = 1'b1;
      ST_ESET: cmd.end_start = 1'b1;
      ST_EDEBT: cmd.debt_step = sts.flush_more;
      ST_EEM: cmd.emit_held = 1'b1;
      ST_END: cmd.end_done = 1'b1;
      ST_OUT: cmd.finish = !out_full;
      default: cmd = '0;
    endcase
  end
endmodule

// ===== hw/rtl/ntfh_dp.sv =====
// Datapath with the hold memory, key matcher, newline debt and FNV-1a hash.
`timescale 1ns / 1ps
module ntfh_dp #(
  parameter int HOLD_DEPTH = ntfh_pkg::HOLD_DEPTH_DEF,
  parameter int NEWLINE_COUNT_BITS = ntfh_pkg::NEWLINE_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ntfh_pkg::in_item_t  in_item,
  input  ntfh_pkg::cmd_t      cmd,
  output ntfh_pkg::sts_t      sts,
  output ntfh_pkg::out_item_t result
);
  import ntfh_pkg::*;

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);
  localparam logic [NEWLINE_COUNT_BITS-1:0] DEBT_MAX = '1;

  logic [7:0] hold_mem [HOLD_DEPTH];
  logic [7:0] rd_data;
  logic [7:0] cur;
  logic       last;
  logic       lf_pend;
  logic [63:0] running_hash;
  logic [CW-1:0] hold_count;
  logic [CW-1:0] nb_len;
  logic [CW-1:0] nb_len_prev;
  logic       last_cr;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] flush_len;
  logic [CW-1:0] trim_len;
  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] kidx;
  logic [3:0] kidx_next;
  logic       line_has_content;
  logic       body_started;
  logic [NEWLINE_COUNT_BITS-1:0] debt;
  logic       overflow_seen;
  logic       debt_more;
  logic [7:0] low;
  logic       blank;
  logic       push;
  logic       drop;
  logic       take;
  logic       emit;
  logic       do_push;
  logic [7:0] hb;
  logic       hen;

  assign low = (cur >= 8'h41 && cur <= 8'h5a) ? cur + 8'd32 : cur;
  assign blank = is_blank(cur);

  // Byte classification: hold it, drop the line, or move to the keep phase.
  always_comb begin
    push = 1'b0;
    drop = 1'b0;
    take = 1'b0;
    phase_next = phase;
    kidx_next = kidx;
    case (phase)
      PH_LEAD: begin
        if (blank) push = 1'b1;
        else if (low == key_char(4'd0)) begin
          push = 1'b1;
          phase_next = PH_KEY;
          kidx_next = 4'd1;
        end else take = 1'b1;
      end
      PH_KEY: begin
        if (cur == CH_EQ) begin
          if (kidx == KEY_LEN) drop = 1'b1;
          else take = 1'b1;
        end else if (blank) begin
          if (kidx == KEY_LEN) begin
            push = 1'b1;
            phase_next = PH_TAIL;
          end else take = 1'b1;
        end else if (kidx < KEY_LEN && low == key_char(kidx)) begin
          push = 1'b1;
          kidx_next = kidx + 4'd1;
        end else take = 1'b1;
      end
      PH_TAIL: begin
        if (blank) push = 1'b1;
        else if (cur == CH_EQ) drop = 1'b1;
        else take = 1'b1;
      end
      PH_KEEP: take = 1'b1;
      default: phase_next = phase;
    endcase
    if (drop) phase_next = PH_DROP;
    if (take) phase_next = PH_KEEP;
    emit = take && !blank && (cur != CH_CR);
    if (take && !emit) push = 1'b1;
  end

  assign do_push = cmd.classify && !lf_pend && push && (hold_count < DEPTH_C);
  assign trim_len = last_cr ? nb_len_prev : nb_len;
  assign debt_more = !line_has_content && (debt != '0);

  assign sts.is_lf = lf_pend;
  assign sts.is_last = last;
  assign sts.emit = emit;
  assign sts.flush_more = rd_ptr < flush_len;
  assign sts.debt_more = debt_more;

  // Hash input selection: owed newlines, held bytes or the current byte.
  always_comb begin
    hen = 1'b0;
    hb = cur;
    if (cmd.debt_step && debt_more) begin
      hen = 1'b1;
      hb = CH_LF;
    end else if (cmd.emit_held) begin
      hen = 1'b1;
      hb = rd_data;
    end else if (cmd.emit_cur) begin
      hen = 1'b1;
      hb = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) hold_mem[hold_count[AW-1:0]] <= cur;
    rd_data <= hold_mem[rd_ptr[AW-1:0]];
    if (cmd.capture) begin
      cur <= in_item.data_byte;
      last <= in_item.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      running_hash <= FNV_BASIS;
      hold_count <= '0;
      nb_len <= '0;
      nb_len_prev <= '0;
      last_cr <= 1'b0;
      rd_ptr <= '0;
      flush_len <= '0;
      phase <= PH_LEAD;
      kidx <= '0;
      line_has_content <= 1'b0;
      body_started <= 1'b0;
      debt <= '0;
      overflow_seen <= 1'b0;
      lf_pend <= 1'b0;
    end else begin
      if (cmd.capture) lf_pend <= (in_item.data_byte == CH_LF);
      if (hen) running_hash <= fnv_mul(running_hash ^ {56'd0, hb});
      if (cmd.debt_step && debt_more) debt <= debt - 1'b1;
      if (cmd.emit_held || cmd.emit_cur) begin
        line_has_content <= 1'b1;
        body_started <= 1'b1;
      end
      if (cmd.emit_held) rd_ptr <= rd_ptr + 1'b1;
      if (cmd.classify && !lf_pend) begin
        phase <= phase_next;
        kidx <= kidx_next;
        if (push) begin
          if (hold_count < DEPTH_C) begin
            hold_count <= hold_count + 1'b1;
            nb_len_prev <= nb_len;
            if (!blank) nb_len <= hold_count + 1'b1;
            last_cr <= (cur == CH_CR);
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        if (drop) begin
          hold_count <= '0;
          nb_len <= '0;
          nb_len_prev <= '0;
          last_cr <= 1'b0;
        end
        if (emit) begin
          flush_len <= hold_count;
          rd_ptr <= '0;
        end
      end
      if (cmd.emit_cur) begin
        hold_count <= '0;
        nb_len <= '0;
        nb_len_prev <= '0;
        last_cr <= 1'b0;
        rd_ptr <= '0;
      end
      if (cmd.end_start) begin
        flush_len <= (phase != PH_DROP) ? trim_len : '0;
        rd_ptr <= '0;
      end
      if (cmd.end_done) begin
        if (phase != PH_DROP && body_started) begin
          if (debt != DEBT_MAX) debt <= debt + 1'b1;
          else overflow_seen <= 1'b1;
        end
        hold_count <= '0;
        nb_len <= '0;
        nb_len_prev <= '0;
        last_cr <= 1'b0;
        rd_ptr <= '0;
        flush_len <= '0;
        phase <= PH_LEAD;
        kidx <= '0;
        line_has_content <= 1'b0;
        lf_pend <= 1'b0;
      end
    end
  end

  assign result.hash_value = body_started ? running_hash : 64'd0;
  assign result.body_empty = !body_started;
  assign result.hold_overflow = overflow_seen;
endmodule

// ===== hw/rtl/normalized_text_fnv1a64_hash_core.sv =====
// Top level of the normalized text FNV-1a 64-bit hash core.
// Each byte is captured while idle and then classified; a byte that is only held or
// skipped ends there, and a byte that releases held text then hashes each owed newline,
// each held byte and itself. A line end hashes the owed newlines when any held bytes are
// kept, then the kept held bytes; the last byte adds a closing line end and an output step.
// Input is taken only while idle, so it stalls during flushes and on a full output.
// Reset is synchronous and returns the hash to the FNV offset basis with nothing held.
`timescale 1ns / 1ps
module normalized_text_fnv1a64_hash_core #(
  parameter int HOLD_DEPTH = ntfh_pkg::HOLD_DEPTH_DEF,
  parameter int NEWLINE_COUNT_BITS = ntfh_pkg::NEWLINE_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ntfh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ntfh_pkg::out_item_t out_data
);
  import ntfh_pkg::*;

  cmd_t cmd;
  sts_t sts;
  out_item_t result;

  ntfh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_full(out_valid && out_stall), .sts(sts), .cmd(cmd)
  );

  ntfh_dp #(.HOLD_DEPTH(HOLD_DEPTH), .NEWLINE_COUNT_BITS(NEWLINE_COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd), .sts(sts), .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data <= result;
  end
endmodule

// ===== hw/rtl/ntfh_checker.sv =====
// Port-level checker for the normalized text hash core, with its bind.
`timescale 1ns / 1ps
module ntfh_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ntfh_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out item changed");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.body_empty |-> out_data.hash_value == 64'd0) else $error("empty hash");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("valid after reset");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("byte taken twice in a row");
endmodule

bind normalized_text_fnv1a64_hash_core ntfh_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
